// ----- hdl/ntc_c2t_pkg.sv -----
`default_nettype none
package ntc_c2t_pkg;

	// field and register widths
	localparam int CODE_W = 16;
	localparam int TEMP_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int RES_W = 19;
	localparam int ROM_IDX_W = 8;

	// lhs = code * bias * 10, product = entry * (ref - code)
	localparam int MUL_W = 2 * CODE_W;
	localparam int LHS_W = MUL_W + 4;
	localparam int PROD_W = RES_W + CODE_W;

	localparam int TABLE_ENTRIES_DEF = 201;
	localparam int ROM_POPULATED = 161;
	localparam int DECI_DEGC_PER_STEP = 5;

	localparam logic [TEMP_W-1:0] TEMP_OOR = 16'hFFFF;
	localparam logic [CODE_W-1:0] REF_RESET = 16'd30000;
	localparam logic [CODE_W-1:0] BIAS_RESET = 16'd10000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_OHM = 2'd1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PREP,
		ST_LHS,
		ST_SCAN,
		ST_DONE
	} state_t;

	// descending thermistor resistance, tenths of ohms, 0 C to 80 C in 0.5 C steps
	function automatic logic [RES_W-1:0] rom_value(input logic [ROM_IDX_W-1:0] idx);
		logic [RES_W-1:0] v;
		case (idx)
			8'd0: v = 19'd326242;   8'd1: v = 19'd318043;   8'd2: v = 19'd310073;
			8'd3: v = 19'd302328;   8'd4: v = 19'd294799;   8'd5: v = 19'd287479;
			8'd6: v = 19'd280363;   8'd7: v = 19'd273445;   8'd8: v = 19'd266718;
			8'd9: v = 19'd260176;   8'd10: v = 19'd253814;  8'd11: v = 19'd247626;
			8'd12: v = 19'd241607;  8'd13: v = 19'd235753;  8'd14: v = 19'd230057;
			8'd15: v = 19'd224516;  8'd16: v = 19'd219124;  8'd17: v = 19'd213878;
			8'd18: v = 19'd208773;  8'd19: v = 19'd203805;  8'd20: v = 19'd198969;
			8'd21: v = 19'd194262;  8'd22: v = 19'd189680;  8'd23: v = 19'd185220;
			8'd24: v = 19'd180878;  8'd25: v = 19'd176649;  8'd26: v = 19'd172532;
			8'd27: v = 19'd168523;  8'd28: v = 19'd164619;  8'd29: v = 19'd160816;
			8'd30: v = 19'd157113;  8'd31: v = 19'd153505;  8'd32: v = 19'd149990;
			8'd33: v = 19'd146566;  8'd34: v = 19'd143230;  8'd35: v = 19'd139980;
			8'd36: v = 19'd136812;  8'd37: v = 19'd133726;  8'd38: v = 19'd130717;
			8'd39: v = 19'd127785;  8'd40: v = 19'd124928;  8'd41: v = 19'd122142;
			8'd42: v = 19'd119426;  8'd43: v = 19'd116778;  8'd44: v = 19'd114197;
			8'd45: v = 19'd111680;  8'd46: v = 19'd109225;  8'd47: v = 19'd106832;
			8'd48: v = 19'd104498;  8'd49: v = 19'd102220;  8'd50: v = 19'd100000;
			8'd51: v = 19'd97834;   8'd52: v = 19'd95721;   8'd53: v = 19'd93659;
			8'd54: v = 19'd91647;   8'd55: v = 19'd89685;   8'd56: v = 19'd87770;
			8'd57: v = 19'd85901;   8'd58: v = 19'd84077;   8'd59: v = 19'd82297;
			8'd60: v = 19'd80560;   8'd61: v = 19'd78864;   8'd62: v = 19'd77208;
			8'd63: v = 19'd75592;   8'd64: v = 19'd74014;   8'd65: v = 19'd72474;
			8'd66: v = 19'd70970;   8'd67: v = 19'd69501;   8'd68: v = 19'd68066;
			8'd69: v = 19'd66666;   8'd70: v = 19'd65297;   8'd71: v = 19'd63961;
			8'd72: v = 19'd62656;   8'd73: v = 19'd61381;   8'd74: v = 19'd60135;
			8'd75: v = 19'd58918;   8'd76: v = 19'd57729;   8'd77: v = 19'd56567;
			8'd78: v = 19'd55432;   8'd79: v = 19'd54323;   8'd80: v = 19'd53239;
			8'd81: v = 19'd52179;   8'd82: v = 19'd51144;   8'd83: v = 19'd50132;
			8'd84: v = 19'd49142;   8'd85: v = 19'd48175;   8'd86: v = 19'd47229;
			8'd87: v = 19'd46305;   8'd88: v = 19'd45401;   8'd89: v = 19'd44517;
			8'd90: v = 19'd43653;   8'd91: v = 19'd42808;   8'd92: v = 19'd41981;
			8'd93: v = 19'd41173;   8'd94: v = 19'd40382;   8'd95: v = 19'd39609;
			8'd96: v = 19'd38852;   8'd97: v = 19'd38112;   8'd98: v = 19'd37388;
			8'd99: v = 19'd36680;   8'd100: v = 19'd35987;  8'd101: v = 19'd35309;
			8'd102: v = 19'd34646;  8'd103: v = 19'd33997;  8'd104: v = 19'd33361;
			8'd105: v = 19'd32739;  8'd106: v = 19'd32131;  8'd107: v = 19'd31535;
			8'd108: v = 19'd30952;  8'd109: v = 19'd30381;  8'd110: v = 19'd29823;
			8'd111: v = 19'd29276;  8'd112: v = 19'd28740;  8'd113: v = 19'd28216;
			8'd114: v = 19'd27703;  8'd115: v = 19'd27200;  8'd116: v = 19'd26708;
			8'd117: v = 19'd26226;  8'd118: v = 19'd25753;  8'd119: v = 19'd25291;
			8'd120: v = 19'd24838;  8'd121: v = 19'd24395;  8'd122: v = 19'd23960;
			8'd123: v = 19'd23534;  8'd124: v = 19'd23117;  8'd125: v = 19'd22709;
			8'd126: v = 19'd22309;  8'd127: v = 19'd21916;  8'd128: v = 19'd21532;
			8'd129: v = 19'd21156;  8'd130: v = 19'd20787;  8'd131: v = 19'd20425;
			8'd132: v = 19'd20071;  8'd133: v = 19'd19723;  8'd134: v = 19'd19383;
			8'd135: v = 19'd19049;  8'd136: v = 19'd18722;  8'd137: v = 19'd18401;
			8'd138: v = 19'd18087;  8'd139: v = 19'd17779;  8'd140: v = 19'd17477;
			8'd141: v = 19'd17180;  8'd142: v = 19'd16890;  8'd143: v = 19'd16605;
			8'd144: v = 19'd16326;  8'd145: v = 19'd16052;  8'd146: v = 19'd15783;
			8'd147: v = 19'd15520;  8'd148: v = 19'd15261;  8'd149: v = 19'd15008;
			8'd150: v = 19'd14759;  8'd151: v = 19'd14515;  8'd152: v = 19'd14276;
			8'd153: v = 19'd14042;  8'd154: v = 19'd13811;  8'd155: v = 19'd13585;
			8'd156: v = 19'd13364;  8'd157: v = 19'd13146;  8'd158: v = 19'd12933;
			8'd159: v = 19'd12724;  8'd160: v = 19'd12518;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/ntc_c2t_ram.sv -----
`default_nettype none
module ntc_c2t_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/ntc_thermistor_code_to_temp.sv -----
// flow: an input transfer leads to ST_PREP; a code at or above the reference goes
//   straight to ST_DONE, otherwise ST_LHS and ST_SCAN run until the scan stops at index i
// throughput: one item at a time, bound by the table scan through the single RAM port, one
//   entry per cycle, plus any output stall; no new input is taken until the result is loaded
// reset: async active low; registers return to 3.0 V reference and 10000 ohm bias,
//   then the table RAM is loaded with all USED entries (161) before the first input is taken
`default_nettype none
module ntc_thermistor_code_to_temp #(
	parameter int TABLE_ENTRIES = ntc_c2t_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// fields: raw_code [15:0]
	input  wire logic [ntc_c2t_pkg::CODE_W-1:0]     s_tdata,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// fields: temp_deci_degc [15:0]
	output logic      [ntc_c2t_pkg::TEMP_W-1:0]     m_tdata,
	// fields: out_of_range [0]
	output logic                                    m_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	input  wire logic                               cfg_we,
	input  wire logic [ntc_c2t_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ntc_c2t_pkg::CODE_W-1:0]     cfg_wdata
);
	import ntc_c2t_pkg::*;

	localparam int USED = (TABLE_ENTRIES < ROM_POPULATED) ? TABLE_ENTRIES : ROM_POPULATED;
	localparam int IDX_W = $clog2(USED);
	localparam int CNT_W = $clog2(USED + 1);

	state_t state_q, state_d;

	logic [CODE_W-1:0] ref_q, bias_q;
	logic [CODE_W-1:0] code_q, diff_q;
	logic [MUL_W-1:0]  mul_q;
	logic [LHS_W-1:0]  lhs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  addr;
	logic              ram_we, ram_re;
	logic [RES_W-1:0]  ram_rdata;

	logic              v_s1, v_s2;
	logic [IDX_W-1:0]  idx_s1, idx_s2;
	logic [PROD_W-1:0] prod_s2;

	logic [TEMP_W-1:0] res_temp_q;
	logic              res_oor_q;
	logic              out_load;

	// scan decision on the product stage
	logic              over, hit;
	logic              fin_oor, fin_hit;
	logic              issue;

	assign addr = cnt_q[IDX_W-1:0];
	assign over = lhs_q > LHS_W'(prod_s2);
	assign hit = lhs_q >= LHS_W'(prod_s2);
	assign fin_oor = v_s2 && ((idx_s2 == '0 && over) ||
		(!hit && idx_s2 == IDX_W'(USED - 1)));
	assign fin_hit = v_s2 && hit && !(idx_s2 == '0 && over);
	assign issue = (state_q == ST_SCAN) && (cnt_q < CNT_W'(USED)) && !fin_oor && !fin_hit;

	// table storage
	ntc_c2t_ram #(
		.WIDTH(RES_W),
		.DEPTH(USED)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (addr),
		.wdata(rom_value(ROM_IDX_W'(addr))),
		.rdata(ram_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_re = 1'b0;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				ram_we = 1'b1;
				if (cnt_q == CNT_W'(USED - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = (code_q >= ref_q) ? ST_DONE : ST_LHS;
			end
			ST_LHS: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				ram_re = issue;
				if (fin_oor || fin_hit) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	// control registers: config, address counter, scan valids, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= REF_RESET;
			bias_q <= BIAS_RESET;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_REFERENCE_CODE: ref_q <= cfg_wdata;
					REG_BIAS_OHM:       bias_q <= cfg_wdata;
					default:            ;
				endcase
			end
			if (state_q == ST_LHS) begin
				cnt_q <= '0;
			end else if (ram_we || issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1 && !fin_oor && !fin_hit;
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// datapath: multiplies, scan pipeline, result
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			code_q <= s_tdata;
		end
		if (state_q == ST_PREP) begin
			diff_q <= ref_q - code_q;
			mul_q <= code_q * bias_q;
			res_temp_q <= TEMP_OOR;
			res_oor_q <= 1'b1;
		end
		if (state_q == ST_LHS) begin
			lhs_q <= {1'b0, mul_q, 3'b000} + {3'b000, mul_q, 1'b0};
		end
		idx_s1 <= addr;
		idx_s2 <= idx_s1;
		prod_s2 <= ram_rdata * diff_q;
		if (fin_hit) begin
			res_temp_q <= TEMP_W'(idx_s2) * TEMP_W'(DECI_DEGC_PER_STEP);
			res_oor_q <= 1'b0;
		end
		if (out_load) begin
			m_tdata <= res_temp_q;
			m_tuser <= res_oor_q;
		end
	end

`ifndef SYNTHESIS
	// flag and code agree, in-range temperatures never reach the marker
	a_flag_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == (m_tdata == TEMP_OOR)))
		else $error("out_of_range flag disagrees with temperature code");

	// no scan still in flight while a new item can be taken
	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!v_s1 && !v_s2))
		else $error("scan pipeline busy while idle");

	// scan never looks past the last populated entry
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (idx_s2 <= IDX_W'(USED - 1)))
		else $error("scan index past table end");

	// a scan that reaches the last entry always ends with a decision
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && idx_s2 == IDX_W'(USED - 1)) |-> (fin_oor || fin_hit))
		else $error("scan reached last entry without a decision");
`endif

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
module tb_top;
	import ntc_c2t_pkg::*;

	// spare register indexes, writes there must leave both registers alone
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int ENTRIES_USED = (TABLE_ENTRIES_DEF < ROM_POPULATED) ?
		TABLE_ENTRIES_DEF : ROM_POPULATED;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 10;
	localparam int END_WAIT = 180;

	typedef struct packed {
		logic [TEMP_W-1:0] temp_deci_degc;
		logic              out_of_range;
	} reading_t;

	// thermistor resistance in tenths of ohms, 0 C to 80 C in half degree steps
	logic [RES_W-1:0] therm_tenths [0:ROM_POPULATED-1] = '{
		326242, 318043, 310073, 302328, 294799, 287479, 280363, 273445, 266718, 260176,
		253814, 247626, 241607, 235753, 230057, 224516, 219124, 213878, 208773, 203805,
		198969, 194262, 189680, 185220, 180878, 176649, 172532, 168523, 164619, 160816,
		157113, 153505, 149990, 146566, 143230, 139980, 136812, 133726, 130717, 127785,
		124928, 122142, 119426, 116778, 114197, 111680, 109225, 106832, 104498, 102220,
		100000, 97834, 95721, 93659, 91647, 89685, 87770, 85901, 84077, 82297,
		80560, 78864, 77208, 75592, 74014, 72474, 70970, 69501, 68066, 66666,
		65297, 63961, 62656, 61381, 60135, 58918, 57729, 56567, 55432, 54323,
		53239, 52179, 51144, 50132, 49142, 48175, 47229, 46305, 45401, 44517,
		43653, 42808, 41981, 41173, 40382, 39609, 38852, 38112, 37388, 36680,
		35987, 35309, 34646, 33997, 33361, 32739, 32131, 31535, 30952, 30381,
		29823, 29276, 28740, 28216, 27703, 27200, 26708, 26226, 25753, 25291,
		24838, 24395, 23960, 23534, 23117, 22709, 22309, 21916, 21532, 21156,
		20787, 20425, 20071, 19723, 19383, 19049, 18722, 18401, 18087, 17779,
		17477, 17180, 16890, 16605, 16326, 16052, 15783, 15520, 15261, 15008,
		14759, 14515, 14276, 14042, 13811, 13585, 13364, 13146, 12933, 12724,
		12518
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic [CODE_W-1:0]    s_tdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TEMP_W-1:0]    m_tdata;
	logic                 m_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_REFERENCE_CODE;
	logic [CODE_W-1:0]    cfg_wdata = '0;

	// local copy of the divider settings
	logic [CODE_W-1:0] model_ref = REF_RESET;
	logic [CODE_W-1:0] model_bias = BIAS_RESET;

	logic [CODE_W-1:0] pending_codes [$];
	reading_t          expected_readings [$];
	int                codes_in_flight = 0;
	int                gap_pct = 0;
	int                stall_pct = 0;
	logic              in_taken = 1'b0;
	int                quiet_cycles = 0;
	int                failures = 0;
	int                codes_sent = 0;
	int                in_span_seen = 0;
	int                flagged_seen = 0;
	int                settings_used = 1;

	ntc_thermistor_code_to_temp uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// divider resistance vs table, cross multiplied, first entry not above it
	function automatic reading_t predict_reading(input logic [CODE_W-1:0] code);
		reading_t   r;
		logic [63:0] lhs;
		logic [63:0] diff;
		int          idx;
		r.temp_deci_degc = TEMP_OOR;
		r.out_of_range = 1'b1;
		if (code < model_ref) begin
			lhs = 64'(code) * 64'(model_bias) * 64'd10;
			diff = 64'(model_ref) - 64'(code);
			if (lhs <= 64'(therm_tenths[0]) * diff &&
					lhs >= 64'(therm_tenths[ENTRIES_USED-1]) * diff) begin
				idx = 0;
				while (idx < ENTRIES_USED - 1 && lhs < 64'(therm_tenths[idx]) * diff)
					idx++;
				r.temp_deci_degc = TEMP_W'(idx * DECI_DEGC_PER_STEP);
				r.out_of_range = 1'b0;
			end
		end
		return r;
	endfunction

	// code whose resistance lands near one table entry at the current settings
	function automatic logic [CODE_W-1:0] code_near_entry(input int idx, input int off);
		longint den;
		longint c;
		den = 10 * longint'(model_bias) + longint'(therm_tenths[idx]);
		c = longint'(model_ref) * longint'(therm_tenths[idx]) / den + off;
		if (c < 0)
			c = 0;
		if (c > 65535)
			c = 65535;
		return CODE_W'(c);
	endfunction

	// source side: present queued codes, random gaps between transfers; random m_tready stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
			if (!s_tvalid || in_taken) begin
				if (pending_codes.size() != 0 && $urandom_range(99) >= gap_pct) begin
					s_tdata <= pending_codes.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sample both sides and config writes, predict on input transfer, check on output transfer
	always @(posedge clk) begin
		reading_t want;
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_REFERENCE_CODE: model_ref = cfg_wdata;
					REG_BIAS_OHM: model_bias = cfg_wdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_readings.size() == 0) begin
					$error("result with nothing pending: temp_deci_degc %0d out_of_range %0d",
						m_tdata, m_tuser);
					failures++;
				end else begin
					want = expected_readings.pop_front();
					if (m_tdata !== want.temp_deci_degc) begin
						$error("temp_deci_degc expected %0d actual %0d",
							want.temp_deci_degc, m_tdata);
						failures++;
					end
					if (m_tuser !== want.out_of_range) begin
						$error("out_of_range expected %0d actual %0d",
							want.out_of_range, m_tuser);
						failures++;
					end
					if (want.out_of_range)
						flagged_seen++;
					else
						in_span_seen++;
				end
			end
			if (s_tvalid && s_tready) begin
				expected_readings.push_back(predict_reading(s_tdata));
				codes_in_flight--;
				codes_sent++;
			end
			// watchdog on cycles without any transfer
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic queue_code(input logic [CODE_W-1:0] code);
		pending_codes.push_back(code);
		codes_in_flight++;
	endtask

	// block idle: every code taken and every reading back
	task automatic settle();
		while (codes_in_flight != 0 || expected_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_pace(input int mode);
		gap_pct = (mode == 1) ? 52 : (mode == 3) ? 16 : 0;
		stall_pct = (mode == 2) ? 52 : (mode == 3) ? 16 : 0;
	endtask

	// one register setting with mostly table-hitting codes and some noise
	task automatic sweep_phase(input logic [CODE_W-1:0] ref_val,
			input logic [CODE_W-1:0] bias_val, input int count, input int mode);
		int                k;
		int                pick;
		logic [CODE_W-1:0] code;
		write_reg(REG_REFERENCE_CODE, ref_val);
		write_reg(REG_BIAS_OHM, bias_val);
		if ($urandom_range(1) == 0)
			write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CODE_W'($urandom));
		@(posedge clk);
		set_pace(mode);
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 70)
				code = code_near_entry($urandom_range(ENTRIES_USED - 1),
					int'($urandom_range(6)) - 3);
			else if (pick < 80)
				code = CODE_W'($urandom_range(16'hFFFF, model_ref));
			else if (pick < 85)
				code = CODE_W'($urandom_range(3));
			else
				code = CODE_W'($urandom);
			queue_code(code);
		end
		settle();
		settings_used++;
	endtask

	initial begin
		int p;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: zero code, full scale, code at and just under reference, patterns, table ends
		@(posedge clk);
		set_pace(0);
		queue_code(16'd0);
		queue_code(16'd1);
		queue_code(16'hFFFF);
		queue_code(REF_RESET);
		queue_code(REF_RESET - 16'd1);
		queue_code(16'h5555);
		queue_code(16'hAAAA);
		queue_code(code_near_entry(0, 0));
		queue_code(code_near_entry(0, 1));
		queue_code(code_near_entry(ENTRIES_USED - 1, 0));
		queue_code(code_near_entry(ENTRIES_USED - 1, -1));
		queue_code(code_near_entry(80, 0));
		settle();

		// resistance inside the span, exactly on the first entry, just past it, and code at the reference
		write_reg(REG_REFERENCE_CODE, 16'd3334);
		write_reg(REG_BIAS_OHM, 16'd49);
		@(posedge clk);
		set_pace(2);
		queue_code(16'd3328);
		queue_code(16'd3329);
		queue_code(16'd3330);
		queue_code(16'd3333);
		queue_code(16'd3334);
		settle();
		settings_used++;

		// resistance exactly on the last populated entry, just under it, and above it
		write_reg(REG_REFERENCE_CODE, 16'd12528);
		write_reg(REG_BIAS_OHM, 16'd1);
		@(posedge clk);
		set_pace(1);
		queue_code(16'd12517);
		queue_code(16'd12518);
		queue_code(16'd12519);
		queue_code(16'd12527);
		settle();
		settings_used++;

		// writes to spare indexes are dropped
		write_reg(REG_SPARE_2, 16'hFFFF);
		write_reg(REG_SPARE_3, 16'h0000);
		@(posedge clk);
		set_pace(3);
		queue_code(16'd12518);
		queue_code(16'd12517);
		settle();

		// random sweeps over divider settings, extremes and degenerate cases included
		sweep_phase(REF_RESET, BIAS_RESET, 340, 0);
		sweep_phase(16'd65535, 16'd10000, 180, 1);
		sweep_phase(16'd33000, 16'd10000, 180, 2);
		sweep_phase(16'd65535, 16'd65535, 180, 3);
		sweep_phase(16'd50000, 16'd2200, 180, 0);
		sweep_phase(16'd1, 16'd1, 40, 1);
		sweep_phase(16'd0, 16'd12345, 40, 2);
		sweep_phase(REF_RESET, 16'd0, 40, 3);
		sweep_phase(16'd20000, 16'd47000, 180, 0);
		sweep_phase(16'd65535, 16'd1, 150, 1);
		sweep_phase(16'd1, 16'd65535, 40, 2);
		for (p = 0; p < 2; p++)
			sweep_phase(CODE_W'($urandom), CODE_W'($urandom), 150, 3 - p);

		settle();
		repeat (END_WAIT) @(negedge clk);
		if (expected_readings.size() != 0) begin
			$error("%0d readings never arrived", expected_readings.size());
			failures++;
		end
		$display("converted %0d codes under %0d divider settings", codes_sent, settings_used);
		$display("%0d readings inside the table span, %0d flagged out of range",
			in_span_seen, flagged_seen);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
